FILE: rtl/core/sapq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted-array priority queue package
// Shared widths, operation and status codes, controller states and the
// command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package sapq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CNT_W     = 5;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int DATA_W    = 32;
  localparam int MAX_LEN_RST = 16;

  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctl_t;

endpackage

FILE: rtl/core/sorted_array_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted-array priority queue
// One queue of element handles ordered by signed key, highest first and
// first-in first-out among equal keys, with enqueue, dequeue and peek.
// ----------------------------------------------------------------------------
// A transaction is accepted at a clock edge where start is high and busy is
// low. Its result appears on status, elem_out, slots_left and entry_count
// at the next clock edge, with done high for exactly one cycle. It must be
// taken at the edge that ends that cycle, since the receiver cannot stall
// the block. A new transaction may be accepted at the edge that ends the
// done cycle, so the block takes a new transaction only once it is through
// with the last: an idle cycle in which the transaction is captured, then a
// busy execute cycle in which every cell of the sorted row compares and
// shifts at once. Writing max_len (clamped to DEPTH) empties the queue and
// rewinds the peek cursor; write it only while no transaction is in flight.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue #(
  parameter int DEPTH = sapq_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [sapq_pkg::CMD_W-1:0]         cmd,
  input  logic [sapq_pkg::DATA_W-1:0]        elem_in,
  input  logic signed [sapq_pkg::DATA_W-1:0] key_in,
  input  logic                               cfg_we,
  input  logic [sapq_pkg::CNT_W-1:0]         cfg_data,
  output logic                               done,
  output logic [sapq_pkg::STAT_W-1:0]        status,
  output logic [sapq_pkg::DATA_W-1:0]        elem_out,
  output logic [sapq_pkg::CNT_W-1:0]         slots_left,
  output logic [sapq_pkg::CNT_W-1:0]         entry_count
);
  import sapq_pkg::*;

  ctl_t ctl;

  sapq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  sapq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cmd         (cmd),
    .elem_in     (elem_in),
    .key_in      (key_in),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .done        (done),
    .status      (status),
    .elem_out    (elem_out),
    .slots_left  (slots_left),
    .entry_count (entry_count)
  );

endmodule

FILE: rtl/core/sapq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted-array priority queue controller
// Accepts a transaction, then steps the datapath through its execute state.
// ----------------------------------------------------------------------------
module sapq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output sapq_pkg::ctl_t ctl
);
  import sapq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    busy        = 1'b0;
    ctl.capture = 1'b0;
    ctl.execute = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        busy        = 1'b1;
        ctl.execute = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/sapq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted-array priority queue datapath
// Row of key/handle cells kept in descending key order, with per-cell compare
// for insertion, shift-up for removal and a cursor for in-order peeks.
// ----------------------------------------------------------------------------
module sapq_datapath #(
  parameter int DEPTH = sapq_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sapq_pkg::ctl_t               ctl,
  input  logic [sapq_pkg::CMD_W-1:0]   cmd,
  input  logic [sapq_pkg::DATA_W-1:0]  elem_in,
  input  logic signed [sapq_pkg::DATA_W-1:0] key_in,
  input  logic                         cfg_we,
  input  logic [sapq_pkg::CNT_W-1:0]   cfg_data,
  output logic                         done,
  output logic [sapq_pkg::STAT_W-1:0]  status,
  output logic [sapq_pkg::DATA_W-1:0]  elem_out,
  output logic [sapq_pkg::CNT_W-1:0]   slots_left,
  output logic [sapq_pkg::CNT_W-1:0]   entry_count
);
  import sapq_pkg::*;

  localparam int MAX_RST = (DEPTH < MAX_LEN_RST) ? DEPTH : MAX_LEN_RST;

  logic [CMD_W-1:0]         cmd_r;
  logic [DATA_W-1:0]        elem_r;
  logic signed [DATA_W-1:0] key_r;

  logic signed [DATA_W-1:0] key_store [DEPTH];
  logic [DATA_W-1:0]        elem_store [DEPTH];
  logic signed [DATA_W-1:0] key_next [DEPTH];
  logic [DATA_W-1:0]        elem_next [DEPTH];

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  peek_pos;
  logic [CNT_W-1:0]  peek_pos_next;
  logic [CNT_W-1:0]  max_len;
  logic [STAT_W-1:0] status_next;
  logic [DATA_W-1:0] elem_out_next;
  logic [CNT_W-1:0]  slots_next;
  logic [DATA_W-1:0] peek_sel;
  logic [DEPTH-1:0]  keep;
  logic              full;
  logic              empty;

  always_comb begin
    full  = (count >= max_len);
    empty = (count == '0);
    for (int i = 0; i < DEPTH; i++) begin
      keep[i] = (i < int'(count)) && (key_store[i] >= key_r);
    end
    peek_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == int'(peek_pos)) begin
        peek_sel = elem_store[i];
      end
    end
  end

  always_comb begin
    key_next      = key_store;
    elem_next     = elem_store;
    count_next    = count;
    peek_pos_next = peek_pos;
    status_next   = STAT_OK;
    elem_out_next = '0;
    case (cmd_r)
      CMD_ENQ: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          if (!keep[0]) begin
            key_next[0]  = key_r;
            elem_next[0] = elem_r;
          end
          for (int i = 1; i < DEPTH; i++) begin
            if (!keep[i]) begin
              if (keep[i-1]) begin
                key_next[i]  = key_r;
                elem_next[i] = elem_r;
              end else begin
                key_next[i]  = key_store[i-1];
                elem_next[i] = elem_store[i-1];
              end
            end
          end
          count_next = count + CNT_W'(1);
        end
      end
      CMD_DEQ: begin
        if (empty) begin
          status_next = STAT_EMPTY;
        end else begin
          elem_out_next = elem_store[0];
          for (int i = 0; i < DEPTH - 1; i++) begin
            key_next[i]  = key_store[i+1];
            elem_next[i] = elem_store[i+1];
          end
          count_next = count - CNT_W'(1);
        end
      end
      CMD_PEEK: begin
        if (empty) begin
          status_next = STAT_EMPTY;
        end else if (peek_pos >= count) begin
          status_next   = STAT_EMPTY;
          peek_pos_next = '0;
        end else begin
          elem_out_next = peek_sel;
          peek_pos_next = peek_pos + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    slots_next = (max_len > count_next) ? (max_len - count_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= cmd;
      elem_r <= elem_in;
      key_r  <= key_in;
    end
    if (ctl.execute) begin
      key_store   <= key_next;
      elem_store  <= elem_next;
      status      <= status_next;
      elem_out    <= elem_out_next;
      slots_left  <= slots_next;
      entry_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      peek_pos <= '0;
      max_len  <= CNT_W'(MAX_RST);
      done     <= 1'b0;
    end else begin
      done <= ctl.execute;
      if (cfg_we) begin
        if (32'(cfg_data) > DEPTH) begin
          max_len <= CNT_W'(DEPTH);
        end else begin
          max_len <= cfg_data;
        end
        count    <= '0;
        peek_pos <= '0;
      end else if (ctl.execute) begin
        count    <= count_next;
        peek_pos <= peek_pos_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= max_len)
    else $error("entry count exceeds maximum length");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctl.execute))
    else $error("result strobe without execute cycle");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    (ctl.execute && cmd_r == CMD_ENQ && !full) |=>
      (done && entry_count == $past(count) + CNT_W'(1)))
    else $error("accepted enqueue did not add one entry");

  a_peek_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (ctl.execute && cmd_r == CMD_PEEK) |=> (entry_count == $past(count)))
    else $error("peek changed the entry count");
`endif

endmodule

FILE: tb/sapq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue result checker
// Watches the command, configuration and result channels of the sorted-array
// priority queue. Keeps its own sorted copy of the queue, predicts the result
// of every accepted transaction and compares each strobed result, field by
// field, with the oldest prediction. Reports the failure count and the number
// of predictions still outstanding.
// ----------------------------------------------------------------------------
module sapq_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic [sapq_pkg::CMD_W-1:0]          cmd,
  input  logic [sapq_pkg::DATA_W-1:0]         elem_in,
  input  logic signed [sapq_pkg::DATA_W-1:0]  key_in,
  input  logic                                cfg_we,
  input  logic [sapq_pkg::CNT_W-1:0]          cfg_data,
  input  logic                                done,
  input  logic [sapq_pkg::STAT_W-1:0]         status,
  input  logic [sapq_pkg::DATA_W-1:0]         elem_out,
  input  logic [sapq_pkg::CNT_W-1:0]          slots_left,
  input  logic [sapq_pkg::CNT_W-1:0]          entry_count,
  output int                                  errors,
  output int                                  pending
);
  import sapq_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] elem;
    logic [CNT_W-1:0]  slots;
    logic [CNT_W-1:0]  count;
  } outcome_t;

  logic signed [DATA_W-1:0] key_row  [DEPTH_DEF];
  logic        [DATA_W-1:0] elem_row [DEPTH_DEF];
  int held;
  int cursor;
  int limit_len;
  outcome_t awaited_q[$];

  function automatic outcome_t serve(input logic [CMD_W-1:0] op,
                                     input logic [DATA_W-1:0] handle,
                                     input logic signed [DATA_W-1:0] prio);
    outcome_t res;
    int pos;
    int j;
    res = '0;
    res.status = STAT_OK;
    case (op)
      CMD_ENQ: begin
        if (held >= limit_len) begin
          res.status = STAT_FULL;
        end else begin
          pos = held;
          while (pos > 0 && prio > key_row[pos-1]) pos--;
          for (j = held; j > pos; j--) begin
            key_row[j]  = key_row[j-1];
            elem_row[j] = elem_row[j-1];
          end
          key_row[pos]  = prio;
          elem_row[pos] = handle;
          held++;
        end
      end
      CMD_DEQ: begin
        if (held == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.elem = elem_row[0];
          for (j = 1; j < held; j++) begin
            key_row[j-1]  = key_row[j];
            elem_row[j-1] = elem_row[j];
          end
          held--;
        end
      end
      CMD_PEEK: begin
        if (held == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          cursor++;
          if (cursor >= held) begin
            cursor = -1;
            res.status = STAT_EMPTY;
          end else begin
            res.elem = elem_row[cursor];
          end
        end
      end
      default: ;
    endcase
    res.slots = (limit_len > held) ? CNT_W'(limit_len - held) : '0;
    res.count = CNT_W'(held);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      held      = 0;
      cursor    = -1;
      limit_len = MAX_LEN_RST;
      awaited_q.delete();
    end else begin
      if (cfg_we) begin
        limit_len = (cfg_data > DEPTH_DEF) ? DEPTH_DEF : int'(cfg_data);
        held      = 0;
        cursor    = -1;
      end
      if (done) begin
        if (awaited_q.size() == 0) begin
          $error("result strobed with no transaction outstanding");
          errors++;
        end else begin
          want = awaited_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
          end
          if (elem_out !== want.elem) begin
            $error("elem_out: expected %h, actual %h", want.elem, elem_out);
            errors++;
          end
          if (slots_left !== want.slots) begin
            $error("slots_left: expected %0d, actual %0d", want.slots, slots_left);
            errors++;
          end
          if (entry_count !== want.count) begin
            $error("entry_count: expected %0d, actual %0d", want.count, entry_count);
            errors++;
          end
        end
      end
      if (start && !busy) awaited_q.push_back(serve(cmd, elem_in, key_in));
    end
    pending = awaited_q.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority queue testbench
// Drives the sorted-array priority queue with a short directed sequence
// (empty, full, tied and extreme keys, peek wrap-around, the unused command
// and the max_len extremes) and then with random runs of fills, drains, peek
// walks and mixed traffic under several max_len settings and sender idle
// rates. The checker alongside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
  import sapq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int PHASE_ITEMS = 80;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [CMD_W-1:0]          cmd;
  logic [DATA_W-1:0]         elem_in;
  logic signed [DATA_W-1:0]  key_in;
  logic                      cfg_we;
  logic [CNT_W-1:0]          cfg_data;
  logic                      done;
  logic [STAT_W-1:0]         status;
  logic [DATA_W-1:0]         elem_out;
  logic [CNT_W-1:0]          slots_left;
  logic [CNT_W-1:0]          entry_count;
  logic                      took;
  int                        errors;
  int                        pending;
  int                        idle_pct;
  int                        n_op [4];
  int                        n_cfg;

  always #5 clk = ~clk;

  sorted_array_priority_queue DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .elem_in     (elem_in),
    .key_in      (key_in),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .done        (done),
    .status      (status),
    .elem_out    (elem_out),
    .slots_left  (slots_left),
    .entry_count (entry_count)
  );

  sapq_checker CHECK (.*);

  always @(posedge clk) took <= start && !busy;

  // Call after a negedge; returns at a negedge after acceptance and any idle gap.
  task automatic issue(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] handle,
                       input logic signed [DATA_W-1:0] prio);
    start   = 1'b1;
    cmd     = op;
    elem_in = handle;
    key_in  = prio;
    do @(negedge clk); while (!took);
    n_op[op]++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic set_max_len(input logic [CNT_W-1:0] value);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    n_cfg++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'sh7FFF_FFFF;
    if (r == 1) return 32'sh8000_0000;
    if (r < 7) return $signed(DATA_W'($urandom_range(0, 6))) - 3;
    return $urandom;
  endfunction

  function automatic logic [CMD_W-1:0] pick_op(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return CMD_NOP;
    if (r < 85) begin
      case (mode)
        0: return CMD_ENQ;
        1: return CMD_DEQ;
        2: return CMD_PEEK;
        default: ;
      endcase
    end
    case ($urandom_range(0, 2))
      0: return CMD_ENQ;
      1: return CMD_DEQ;
      default: return CMD_PEEK;
    endcase
  endfunction

  initial begin : stimulus
    logic [CNT_W-1:0] settings [8];
    int pcts [4];
    int left;
    int mode;
    int run;
    settings = '{5'd31, 5'd1, 5'd16, 5'd9, 5'd4, 5'd16, 5'd3, 5'd12};
    pcts     = '{0, 52, 0, 27};
    rst      = 1'b1;
    start    = 1'b0;
    cmd      = CMD_ENQ;
    elem_in  = '0;
    key_in   = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    idle_pct = 0;
    n_op     = '{0, 0, 0, 0};
    n_cfg    = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    issue(CMD_DEQ,  32'h0000_0001, 32'sd0);
    issue(CMD_PEEK, 32'h0000_0002, 32'sd0);
    issue(CMD_NOP,  32'hFFFF_FFFF, 32'sh7FFF_FFFF);
    issue(CMD_ENQ,  32'h0000_00A0, 32'sd0);
    issue(CMD_ENQ,  32'hFFFF_FFFF, 32'sh7FFF_FFFF);
    issue(CMD_ENQ,  32'h0000_0000, 32'sh8000_0000);
    issue(CMD_ENQ,  32'h0000_00A1, 32'sd0);
    issue(CMD_ENQ,  32'h5A5A_A5A5, -32'sd1);
    repeat (7) issue(CMD_PEEK, '0, '0);
    issue(CMD_DEQ,  '0, '0);
    issue(CMD_ENQ,  32'h0000_00B5, 32'sd5);
    issue(CMD_PEEK, '0, '0);
    set_max_len(5'd2);
    repeat (3) issue(CMD_ENQ, $urandom, pick_key());
    issue(CMD_NOP, 32'hFFFF_FFFF, -32'sd1);
    set_max_len(5'd0);
    issue(CMD_ENQ, 32'h1234_5678, 32'sd7);
    issue(CMD_DEQ, '0, '0);
    issue(CMD_PEEK, '0, '0);

    for (int p = 0; p < 8; p++) begin
      set_max_len(settings[p]);
      idle_pct = pcts[p % 4];
      left = PHASE_ITEMS;
      while (left > 0) begin
        mode = $urandom_range(0, 3);
        run  = $urandom_range(6, 20);
        while (run > 0 && left > 0) begin
          issue(pick_op(mode), $urandom, pick_key());
          run--;
          left--;
        end
      end
    end

    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    $display("Covered %0d enqueue, %0d dequeue, %0d peek and %0d unused-code transactions",
             n_op[CMD_ENQ], n_op[CMD_DEQ], n_op[CMD_PEEK], n_op[CMD_NOP]);
    $display("over %0d max_len writes, including 0, 1, 16 and an out-of-range 31",
             n_cfg);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
